[hw/rtl/pnn_pkg.sv]
// pnn_pkg: widths, types, state encodings and sizes for the periodic nearest neighbor block
// no dependencies; used by every other file in hw/rtl except pnn_ram

package pnn_pkg;

  localparam int unsigned MAX_SPHERES = 32;
  localparam int unsigned ADDR_W      = $clog2(MAX_SPHERES);
  localparam int unsigned FILL_W      = $clog2(MAX_SPHERES + 1);
  localparam int unsigned IDX_W       = 6;

  localparam int unsigned COORD_W     = 20;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned INT_W       = COORD_W - FRAC_W;
  localparam int unsigned BOX_W       = 13;
  localparam int unsigned LEN_W       = BOX_W + FRAC_W;
  localparam int unsigned SQ_W        = 2 * COORD_W;
  localparam int unsigned D2_W        = SQ_W + 2;
  localparam int unsigned ROOT_W      = D2_W / 2;
  localparam int unsigned SUM_W       = 26;

  localparam int unsigned RED_STEPS   = INT_W;
  localparam int unsigned RED_CNT_W   = $clog2(RED_STEPS);
  localparam int unsigned SQRT_STEPS  = ROOT_W;
  localparam int unsigned DIV_STEPS   = SUM_W;
  localparam int unsigned STEP_W      = $clog2(DIV_STEPS);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(256);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [FILL_W-1:0]  fill_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [SQ_W-1:0]    sq_t;
  typedef logic [D2_W-1:0]    d2_t;
  typedef logic [ROOT_W-1:0]  root_t;
  typedef logic [ROOT_W+1:0]  srem_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [RED_CNT_W-1:0] red_cnt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t r;
  } sphere_t;

  typedef struct packed {
    sphere_t sph;
    logic    last;
  } qent_t;

  typedef struct packed {
    logic             is_summary;
    logic [IDX_W-1:0] sphere_index;
    logic [IDX_W-1:0] neighbor_index;
    logic             found;
    coord_t           nearest_distance;
    coord_t           edge_distance;
    logic [IDX_W-1:0] stored_count;
    logic             last_result;
  } rec_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RED,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_LOAD,
    B_ROW_RD,
    B_ROW_LAT,
    B_SCAN,
    B_ROOT,
    B_EMIT,
    B_DIV,
    B_SUM
  } back_state_e;

endpackage

[hw/rtl/pnn_if.sv]
// pnn_if: valid/ready stream interfaces for sphere input and result output
// depends on pnn_pkg for field widths

interface pnn_in_if;
  logic                  valid;
  logic                  ready;
  pnn_pkg::coord_t       center_x;
  pnn_pkg::coord_t       center_y;
  pnn_pkg::coord_t       center_z;
  pnn_pkg::coord_t       sphere_radius;
  logic                  last_sphere;

  modport source (output valid, center_x, center_y, center_z, sphere_radius, last_sphere,
                  input ready);
  modport sink   (input valid, center_x, center_y, center_z, sphere_radius, last_sphere,
                  output ready);
endinterface

interface pnn_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_summary;
  logic [pnn_pkg::IDX_W-1:0]     sphere_index;
  logic [pnn_pkg::IDX_W-1:0]     neighbor_index;
  logic                          found;
  pnn_pkg::coord_t               nearest_distance;
  pnn_pkg::coord_t               edge_distance;
  logic [pnn_pkg::IDX_W-1:0]     stored_count;
  logic                          last_result;

  modport source (output valid, is_summary, sphere_index, neighbor_index, found,
                  nearest_distance, edge_distance, stored_count, last_result,
                  input ready);
  modport sink   (input valid, is_summary, sphere_index, neighbor_index, found,
                  nearest_distance, edge_distance, stored_count, last_result,
                  output ready);
endinterface

[hw/rtl/pnn_ram.sv]
// pnn_ram: generic single write port, single read port RAM with registered read
// no dependencies

module pnn_ram #(
  parameter int unsigned Width = 80,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/pnn_fifo.sv]
// pnn_fifo: short queue between the front and back parts
// depends on pnn_pkg for the entry type and depth

module pnn_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pnn_pkg::qent_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output pnn_pkg::qent_t data_o,
  output logic           empty_o
);

  pnn_pkg::qent_t                 mem_q [pnn_pkg::QUEUE_DEPTH];
  logic [pnn_pkg::QPTR_W-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [pnn_pkg::QCNT_W-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == pnn_pkg::QCNT_W'(pnn_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == pnn_pkg::QPTR_W'(pnn_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == pnn_pkg::QPTR_W'(pnn_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/pnn_front.sv]
// pnn_front: accepts spheres and reduces each centre modulo the box length
// depends on pnn_pkg and pnn_in_if; feeds pnn_fifo

module pnn_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [pnn_pkg::BOX_W-1:0] box_i,
  pnn_in_if.sink                    in_i,
  output logic                      push_o,
  output pnn_pkg::qent_t            push_data_o,
  input  logic                      full_i
);

  pnn_pkg::front_state_e             state_q, state_d;
  pnn_pkg::red_cnt_t                 cnt_q;
  logic [2:0][pnn_pkg::INT_W-1:0]    hi_q;
  logic [2:0][pnn_pkg::FRAC_W-1:0]   lo_q;
  logic [2:0][pnn_pkg::BOX_W-1:0]    rem_q;
  logic [2:0][pnn_pkg::BOX_W-1:0]    rem_d;
  pnn_pkg::coord_t                   rad_q;
  logic                              last_q;
  logic [pnn_pkg::BOX_W-1:0]         divisor;
  logic [pnn_pkg::BOX_W:0]           shifted;
  logic                              accept;

  assign divisor = (box_i == '0) ? pnn_pkg::BOX_W'(1) : box_i;
  assign accept  = in_i.valid && in_i.ready;

  // one restoring step per cycle on each axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      shifted  = {rem_q[k], hi_q[k][pnn_pkg::INT_W-1]};
      rem_d[k] = (shifted >= {1'b0, divisor}) ? pnn_pkg::BOX_W'(shifted - {1'b0, divisor})
                                              : pnn_pkg::BOX_W'(shifted);
    end
  end

  always_comb begin
    state_d  = state_q;
    in_i.ready = 1'b0;
    push_o   = 1'b0;
    case (state_q)
      pnn_pkg::F_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) state_d = pnn_pkg::F_RED;
      end
      pnn_pkg::F_RED: begin
        if (cnt_q == pnn_pkg::red_cnt_t'(pnn_pkg::RED_STEPS - 1)) state_d = pnn_pkg::F_PUSH;
      end
      pnn_pkg::F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = pnn_pkg::F_IDLE;
        end
      end
      default: state_d = pnn_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pnn_pkg::F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == pnn_pkg::F_RED) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hi_q[0] <= in_i.center_x[pnn_pkg::COORD_W-1:pnn_pkg::FRAC_W];
      hi_q[1] <= in_i.center_y[pnn_pkg::COORD_W-1:pnn_pkg::FRAC_W];
      hi_q[2] <= in_i.center_z[pnn_pkg::COORD_W-1:pnn_pkg::FRAC_W];
      lo_q[0] <= in_i.center_x[pnn_pkg::FRAC_W-1:0];
      lo_q[1] <= in_i.center_y[pnn_pkg::FRAC_W-1:0];
      lo_q[2] <= in_i.center_z[pnn_pkg::FRAC_W-1:0];
      rem_q   <= '0;
      rad_q   <= in_i.sphere_radius;
      last_q  <= in_i.last_sphere;
    end else if (state_q == pnn_pkg::F_RED) begin
      for (int k = 0; k < 3; k++) begin
        hi_q[k]  <= {hi_q[k][pnn_pkg::INT_W-2:0], 1'b0};
        rem_q[k] <= rem_d[k];
      end
    end
  end

  assign push_data_o.sph.x = {rem_q[0][pnn_pkg::INT_W-1:0], lo_q[0]};
  assign push_data_o.sph.y = {rem_q[1][pnn_pkg::INT_W-1:0], lo_q[1]};
  assign push_data_o.sph.z = {rem_q[2][pnn_pkg::INT_W-1:0], lo_q[2]};
  assign push_data_o.sph.r = rad_q;
  assign push_data_o.last  = last_q;

endmodule

[hw/rtl/pnn_back.sv]
// pnn_back: stores spheres, runs the all-pairs search, square root and means
// depends on pnn_pkg, pnn_out_if and pnn_ram; fed by pnn_fifo

module pnn_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pnn_pkg::len_t          len_i,
  input  pnn_pkg::qent_t         qdata_i,
  input  logic                   qempty_i,
  output logic                   qpop_o,
  pnn_out_if.source              out_o
);

  function automatic pnn_pkg::coord_t fold(input pnn_pkg::coord_t a, input pnn_pkg::coord_t b,
                                           input pnn_pkg::len_t len);
    pnn_pkg::len_t r;
    pnn_pkg::len_t alt;
    if (a >= b) begin
      r = pnn_pkg::len_t'(a) - pnn_pkg::len_t'(b);
    end else begin
      r = pnn_pkg::len_t'(a) + len - pnn_pkg::len_t'(b);
    end
    alt = len - r;
    return (r < alt) ? pnn_pkg::coord_t'(r) : pnn_pkg::coord_t'(alt);
  endfunction

  function automatic pnn_pkg::coord_t sat(input pnn_pkg::root_t v);
    return v[pnn_pkg::ROOT_W-1] ? '1 : pnn_pkg::coord_t'(v);
  endfunction

  function automatic logic p4_d2_ok(input pnn_pkg::d2_t d2, input pnn_pkg::d2_t ss);
    return d2 >= ss;
  endfunction

  pnn_pkg::back_state_e state_q, state_d;
  pnn_pkg::fill_t       fill_q, i_q, jr_q;
  pnn_pkg::step_t       step_q;
  pnn_pkg::sphere_t     ent_q, rdata;
  pnn_pkg::addr_t       raddr;
  logic                 we;

  // search pipeline
  logic                    issue, scan_done;
  logic                    p1_v_q, p2_v_q, p3_v_q, p4_v_q;
  pnn_pkg::fill_t          p1_j_q, p2_j_q, p3_j_q, p4_j_q;
  logic [2:0][pnn_pkg::COORD_W-1:0] p2_f_q;
  pnn_pkg::len_t           p2_s_q, p3_s_q, p4_s_q;
  logic [2:0][pnn_pkg::SQ_W-1:0]    p3_sq_q;
  pnn_pkg::d2_t            p3_ss_q, p4_d2_q, d2_sum;
  logic                    have_q;
  pnn_pkg::d2_t            best_q;
  pnn_pkg::fill_t          best_j_q;
  pnn_pkg::len_t           best_s_q;

  // square root and mean dividers
  pnn_pkg::d2_t            sv_q;
  pnn_pkg::srem_t          srem_q;
  pnn_pkg::root_t          sroot_q;
  logic [pnn_pkg::ROOT_W+2:0] srem_sh, strial;
  logic                    sge;
  pnn_pkg::sum_t           dsum_q, gsum_q;
  logic [1:0][pnn_pkg::SUM_W-1:0]  dnum_q;
  logic [1:0][pnn_pkg::FILL_W-1:0] drem_q, drem_d;
  logic [1:0]              dge;
  logic [pnn_pkg::FILL_W:0] dsh;

  // output register
  logic                    out_v_q, slot_free, out_load, row_last;
  pnn_pkg::rec_t           rec_q, rec_d;
  pnn_pkg::coord_t         near_dist, gap;
  pnn_pkg::root_t          gap_raw;

  assign we    = qpop_o && (fill_q < pnn_pkg::fill_t'(pnn_pkg::MAX_SPHERES));
  assign raddr = (state_q == pnn_pkg::B_SCAN) ? jr_q[pnn_pkg::ADDR_W-1:0]
                                              : i_q[pnn_pkg::ADDR_W-1:0];

  pnn_ram #(
    .Width ($bits(pnn_pkg::sphere_t)),
    .Depth (pnn_pkg::MAX_SPHERES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fill_q[pnn_pkg::ADDR_W-1:0]),
    .wdata_i (qdata_i.sph),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign issue     = (state_q == pnn_pkg::B_SCAN) && (jr_q < fill_q);
  assign scan_done = (state_q == pnn_pkg::B_SCAN) && !issue &&
                     !p1_v_q && !p2_v_q && !p3_v_q && !p4_v_q;
  assign d2_sum    = pnn_pkg::d2_t'(p3_sq_q[0]) + pnn_pkg::d2_t'(p3_sq_q[1]) +
                     pnn_pkg::d2_t'(p3_sq_q[2]);

  assign srem_sh = {srem_q[pnn_pkg::ROOT_W:0], sv_q[pnn_pkg::D2_W-1 -: 2]};
  assign strial  = {1'b0, sroot_q, 2'b01};
  assign sge     = (srem_sh >= strial);

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      dsh       = {drem_q[k], dnum_q[k][pnn_pkg::SUM_W-1]};
      dge[k]    = (dsh >= {1'b0, fill_q});
      drem_d[k] = dge[k] ? pnn_pkg::fill_t'(dsh - {1'b0, fill_q}) : pnn_pkg::fill_t'(dsh);
    end
  end

  assign gap_raw   = sroot_q - pnn_pkg::root_t'(best_s_q);
  assign near_dist = have_q ? sat(sroot_q) : '0;
  assign gap       = have_q ? sat(gap_raw) : '0;
  assign slot_free = !out_v_q || out_o.ready;
  assign row_last  = ((i_q + 1'b1) == fill_q);

  always_comb begin
    rec_d = '0;
    if (state_q == pnn_pkg::B_SUM) begin
      rec_d.is_summary       = 1'b1;
      rec_d.found            = 1'b1;
      rec_d.nearest_distance = pnn_pkg::coord_t'(dnum_q[0]);
      rec_d.edge_distance    = pnn_pkg::coord_t'(dnum_q[1]);
      rec_d.stored_count     = pnn_pkg::IDX_W'(fill_q);
      rec_d.last_result      = 1'b1;
    end else begin
      rec_d.sphere_index     = pnn_pkg::IDX_W'(i_q);
      rec_d.neighbor_index   = have_q ? pnn_pkg::IDX_W'(best_j_q) : '0;
      rec_d.found            = have_q;
      rec_d.nearest_distance = near_dist;
      rec_d.edge_distance    = gap;
    end
  end

  always_comb begin
    state_d  = state_q;
    qpop_o   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      pnn_pkg::B_LOAD: begin
        if (!qempty_i) begin
          qpop_o = 1'b1;
          if (qdata_i.last) state_d = pnn_pkg::B_ROW_RD;
        end
      end
      pnn_pkg::B_ROW_RD:  state_d = pnn_pkg::B_ROW_LAT;
      pnn_pkg::B_ROW_LAT: state_d = pnn_pkg::B_SCAN;
      pnn_pkg::B_SCAN: begin
        if (scan_done) state_d = have_q ? pnn_pkg::B_ROOT : pnn_pkg::B_EMIT;
      end
      pnn_pkg::B_ROOT: begin
        if (step_q == pnn_pkg::step_t'(pnn_pkg::SQRT_STEPS - 1)) state_d = pnn_pkg::B_EMIT;
      end
      pnn_pkg::B_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = row_last ? pnn_pkg::B_DIV : pnn_pkg::B_ROW_RD;
        end
      end
      pnn_pkg::B_DIV: begin
        if (step_q == pnn_pkg::step_t'(pnn_pkg::DIV_STEPS - 1)) state_d = pnn_pkg::B_SUM;
      end
      pnn_pkg::B_SUM: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = pnn_pkg::B_LOAD;
        end
      end
      default: state_d = pnn_pkg::B_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pnn_pkg::B_LOAD;
      fill_q  <= '0;
      i_q     <= '0;
      jr_q    <= '0;
      step_q  <= '0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      have_q  <= 1'b0;
      dsum_q  <= '0;
      gsum_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (we) fill_q <= fill_q + 1'b1;
      p1_v_q <= issue;
      p2_v_q <= p1_v_q && (p1_j_q != i_q);
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q && (p4_d2_ok(d2_sum, p3_ss_q));
      if (state_q == pnn_pkg::B_ROW_LAT) begin
        jr_q   <= '0;
        have_q <= 1'b0;
      end else if (issue) begin
        jr_q <= jr_q + 1'b1;
      end
      if (p4_v_q && (!have_q || (p4_d2_q < best_q))) have_q <= 1'b1;
      if (scan_done || (out_load && row_last && state_q == pnn_pkg::B_EMIT)) begin
        step_q <= '0;
      end else if (state_q == pnn_pkg::B_ROOT || state_q == pnn_pkg::B_DIV) begin
        step_q <= step_q + 1'b1;
      end
      if (out_load) begin
        if (state_q == pnn_pkg::B_EMIT) begin
          dsum_q <= dsum_q + pnn_pkg::sum_t'(near_dist);
          gsum_q <= gsum_q + pnn_pkg::sum_t'(gap);
          i_q    <= row_last ? '0 : i_q + 1'b1;
        end else begin
          dsum_q <= '0;
          gsum_q <= '0;
          fill_q <= '0;
          i_q    <= '0;
        end
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pnn_pkg::B_ROW_LAT) ent_q <= rdata;
    p1_j_q <= jr_q;
    p2_j_q <= p1_j_q;
    p2_f_q[0] <= fold(ent_q.x, rdata.x, len_i);
    p2_f_q[1] <= fold(ent_q.y, rdata.y, len_i);
    p2_f_q[2] <= fold(ent_q.z, rdata.z, len_i);
    p2_s_q <= pnn_pkg::len_t'(ent_q.r) + pnn_pkg::len_t'(rdata.r);
    p3_j_q <= p2_j_q;
    p3_s_q <= p2_s_q;
    for (int k = 0; k < 3; k++) begin
      p3_sq_q[k] <= pnn_pkg::sq_t'(p2_f_q[k]) * pnn_pkg::sq_t'(p2_f_q[k]);
    end
    p3_ss_q <= pnn_pkg::d2_t'(p2_s_q) * pnn_pkg::d2_t'(p2_s_q);
    p4_j_q  <= p3_j_q;
    p4_s_q  <= p3_s_q;
    p4_d2_q <= d2_sum;
    if (p4_v_q && (!have_q || (p4_d2_q < best_q))) begin
      best_q   <= p4_d2_q;
      best_j_q <= p4_j_q;
      best_s_q <= p4_s_q;
    end
    if (scan_done) begin
      sv_q    <= best_q;
      srem_q  <= '0;
      sroot_q <= '0;
    end else if (state_q == pnn_pkg::B_ROOT) begin
      sv_q    <= {sv_q[pnn_pkg::D2_W-3:0], 2'b00};
      srem_q  <= sge ? pnn_pkg::srem_t'(srem_sh - strial) : pnn_pkg::srem_t'(srem_sh);
      sroot_q <= {sroot_q[pnn_pkg::ROOT_W-2:0], sge};
    end
    if (scan_done && !have_q) sroot_q <= '0;
    if (out_load && row_last && state_q == pnn_pkg::B_EMIT) begin
      dnum_q[0] <= dsum_q + pnn_pkg::sum_t'(near_dist);
      dnum_q[1] <= gsum_q + pnn_pkg::sum_t'(gap);
      drem_q    <= '0;
    end else if (state_q == pnn_pkg::B_DIV) begin
      for (int k = 0; k < 2; k++) begin
        dnum_q[k] <= {dnum_q[k][pnn_pkg::SUM_W-2:0], dge[k]};
        drem_q[k] <= drem_d[k];
      end
    end
    if (out_load) rec_q <= rec_d;
  end

  assign out_o.valid            = out_v_q;
  assign out_o.is_summary       = rec_q.is_summary;
  assign out_o.sphere_index     = rec_q.sphere_index;
  assign out_o.neighbor_index   = rec_q.neighbor_index;
  assign out_o.found            = rec_q.found;
  assign out_o.nearest_distance = rec_q.nearest_distance;
  assign out_o.edge_distance    = rec_q.edge_distance;
  assign out_o.stored_count     = rec_q.stored_count;
  assign out_o.last_result      = rec_q.last_result;

endmodule

[hw/rtl/periodic_nearest_neighbor.sv]
// periodic_nearest_neighbor: top level, box size register, front, queue and back
// depends on pnn_pkg, pnn_if, pnn_ram, pnn_fifo, pnn_front and pnn_back
//
// spheres arrive on in_i (centre x, y, z and radius, unsigned Q12.8) one transaction
// at a time; a transaction with last_sphere set closes the batch and starts the search
// the front takes one sphere at a time: it accepts it, reduces the centre modulo the
// box length and hands it to a two-entry queue, waiting while the queue is full, so it
// keeps taking spheres while the back part is still busy
// the back stores up to MAX_SPHERES spheres and drops any beyond that
// each per-sphere record reads the row sphere, scans one candidate pair per cycle,
// drains the distance pipeline, runs the square root and loads the output register;
// with no valid neighbor the square root is skipped; the summary record follows after
// the mean divider and a load of the output register
// results leave through out_o as transactions from one output register; when the
// receiver holds ready low the back part waits and the queue fills behind it
// cfg_we_i writes box_size (13 bits) from cfg_wdata_i; it must be written only while
// idle by the user, as the block does not enforce it; reset clears the queue, the fill
// count and the sums and sets box_size to 256; the sphere store is not cleared, so no
// clearing pass is needed

module periodic_nearest_neighbor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pnn_pkg::BOX_W-1:0] cfg_wdata_i,
  pnn_in_if.sink                    in_i,
  pnn_out_if.source                 out_o
);

  logic [pnn_pkg::BOX_W-1:0] box_q;
  logic [pnn_pkg::BOX_W-1:0] box_eff;
  pnn_pkg::len_t             len;
  logic                      q_push, q_full, q_pop, q_empty;
  pnn_pkg::qent_t            q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= pnn_pkg::BOX_RESET;
    end else if (cfg_we_i) begin
      box_q <= cfg_wdata_i;
    end
  end

  assign box_eff = (box_q == '0) ? pnn_pkg::BOX_W'(1) : box_q;
  assign len     = {box_eff, {pnn_pkg::FRAC_W{1'b0}}};

  pnn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_i       (box_q),
    .in_i        (in_i),
    .push_o      (q_push),
    .push_data_o (q_wdata),
    .full_i      (q_full)
  );

  pnn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  pnn_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .len_i    (len),
    .qdata_i  (q_rdata),
    .qempty_i (q_empty),
    .qpop_o   (q_pop),
    .out_o    (out_o)
  );

`ifndef SYNTH
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("queue push while full");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("queue pop while empty");

  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready) else $error("front took two spheres in a row");

  a_summary_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.is_summary |-> out_o.last_result && out_o.found &&
    (out_o.stored_count != '0)) else $error("malformed summary record");
`endif

endmodule

[bench/pnn_tb_checker.sv]
// pnn_tb_checker: watches the sphere and result channels, predicts each record
// and compares; depends on pnn_pkg and pnn_if, reports a mismatch count
module pnn_tb_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pnn_pkg::BOX_W-1:0] cfg_wdata_i,
  pnn_in_if.sink                    in_i,
  pnn_out_if.sink                   out_i,
  output int                        errors_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pnn_pkg::*;

  coord_t xs[MAX_SPHERES];
  coord_t ys[MAX_SPHERES];
  coord_t zs[MAX_SPHERES];
  coord_t rs[MAX_SPHERES];
  int unsigned fill;
  logic [BOX_W-1:0] box;
  rec_t expected_recs[$];

  function automatic longint unsigned fold_axis(coord_t a, coord_t b, longint unsigned len);
    longint unsigned d;
    d = (a > b) ? longint'(a - b) : longint'(b - a);
    d = d % len;
    return (d < len - d) ? d : len - d;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic coord_t sat20(longint unsigned v);
    return (v > 64'hFFFFF) ? 20'hFFFFF : coord_t'(v);
  endfunction

  task automatic predict_batch();
    longint unsigned len, best, d2, s, root;
    logic [SUM_W-1:0] dsum, gsum;
    int unsigned bj;
    bit have;
    rec_t rec;
    len = longint'(box == 0 ? 1 : box) << 8;
    dsum = 0;
    gsum = 0;
    for (int i = 0; i < fill; i++) begin
      have = 0;
      best = 0;
      bj = 0;
      for (int j = 0; j < fill; j++) begin
        if (j == i) continue;
        d2 = fold_axis(xs[i], xs[j], len) ** 2 + fold_axis(ys[i], ys[j], len) ** 2
             + fold_axis(zs[i], zs[j], len) ** 2;
        s = longint'(rs[i]) + rs[j];
        if (d2 < s * s) continue;
        if (!have || d2 < best) begin
          have = 1;
          best = d2;
          bj = j;
        end
      end
      rec = '0;
      rec.sphere_index = IDX_W'(i);
      if (have) begin
        root = int_sqrt(best);
        s = longint'(rs[i]) + rs[bj];
        rec.neighbor_index = IDX_W'(bj);
        rec.found = 1'b1;
        rec.nearest_distance = sat20(root);
        rec.edge_distance = sat20(root - s);
        dsum = dsum + rec.nearest_distance;
        gsum = gsum + rec.edge_distance;
      end
      expected_recs = {expected_recs, rec};
    end
    rec = '0;
    rec.is_summary = 1'b1;
    rec.found = 1'b1;
    rec.nearest_distance = (fill != 0) ? coord_t'(dsum / fill) : '0;
    rec.edge_distance = (fill != 0) ? coord_t'(gsum / fill) : '0;
    rec.stored_count = IDX_W'(fill);
    rec.last_result = 1'b1;
    expected_recs = {expected_recs, rec};
    fill = 0;
  endtask

  task automatic compare_field(string name, longint unsigned exp, longint unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rec_t e;
    if (!rst_ni) begin
      fill = 0;
      box = BOX_RESET;
      errors_o = 0;
      expected_recs.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) box = cfg_wdata_i;
      if (in_i.valid && in_i.ready) begin
        if (fill < MAX_SPHERES) begin
          xs[fill] = in_i.center_x;
          ys[fill] = in_i.center_y;
          zs[fill] = in_i.center_z;
          rs[fill] = in_i.sphere_radius;
          fill++;
        end
        if (in_i.last_sphere) predict_batch();
      end
      if (out_i.valid && out_i.ready) begin
        if (expected_recs.size() == 0) begin
          $error("unexpected result transaction");
          errors_o++;
        end else begin
          e = expected_recs.pop_front();
          compare_field("is_summary", e.is_summary, out_i.is_summary);
          compare_field("sphere_index", e.sphere_index, out_i.sphere_index);
          compare_field("neighbor_index", e.neighbor_index, out_i.neighbor_index);
          compare_field("found", e.found, out_i.found);
          compare_field("nearest_distance", e.nearest_distance, out_i.nearest_distance);
          compare_field("edge_distance", e.edge_distance, out_i.edge_distance);
          compare_field("stored_count", e.stored_count, out_i.stored_count);
          compare_field("last_result", e.last_result, out_i.last_result);
        end
      end
      pending_o = expected_recs.size();
    end
  end
endmodule

[bench/tb_periodic_nearest_neighbor.sv]
// tb_periodic_nearest_neighbor: drives sphere batches and box sizes with random gaps
// depends on pnn_pkg, pnn_if, the block and pnn_tb_checker
module tb_periodic_nearest_neighbor;
  timeunit 1ns;
  timeprecision 1ps;
  import pnn_pkg::*;

  localparam longint LIMIT = 3000000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [BOX_W-1:0] cfg_wdata_i = '0;
  int errors, pending;
  longint cycles = 0;
  logic [BOX_W-1:0] cur_box = BOX_RESET;

  pnn_in_if  in_ch();
  pnn_out_if out_ch();

  periodic_nearest_neighbor dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  pnn_tb_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_i(in_ch.sink), .out_i(out_ch.sink),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL periodic_nearest_neighbor");
      $finish;
    end
  end

  // result side: random stalls, with quiet stretches
  always @(posedge clk_i) begin
    int w;
    if (!rst_ni) begin
      out_ch.ready <= 0;
    end else begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      out_ch.ready <= 1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      if (w > 0) begin
        out_ch.ready <= 0;
        repeat (w - 1) @(posedge clk_i);
      end
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom_range(0, 20'hFFFFF));
      1: return coord_t'($urandom_range(0, (int'(cur_box == 0 ? 1 : cur_box) << 8) - 1));
      default: return coord_t'($urandom_range(0, 4096));
    endcase
  endfunction

  task automatic send_sphere(coord_t x, coord_t y, coord_t z, coord_t r, logic lst,
                             bit quiet);
    int g;
    g = quiet ? 0 : $urandom_range(0, 19);
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.center_x <= x;
    in_ch.center_y <= y;
    in_ch.center_z <= z;
    in_ch.sphere_radius <= r;
    in_ch.last_sphere <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic set_box(logic [BOX_W-1:0] v);
    in_ch.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    cur_box = v;
  endtask

  task automatic random_batch(int n, int mode, bit quiet);
    coord_t r;
    for (int k = 0; k < n; k++) begin
      r = ($urandom_range(0, 7) == 0) ? coord_t'($urandom_range(0, 20'hFFFFF))
                                      : coord_t'($urandom_range(0, 2000));
      send_sphere(rand_coord(mode), rand_coord(mode), rand_coord(mode), r, k == n - 1,
                  quiet);
    end
  endtask

  initial begin
    int sent, n;
    logic [BOX_W-1:0] boxes[6];
    boxes = '{13'd1, 13'd4096, 13'd0, 13'h1FFF, 13'd7, 13'd256};
    in_ch.valid = 0;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.center_z = '0;
    in_ch.sphere_radius = '0;
    in_ch.last_sphere = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: lone sphere, extremes, overlap, ties, wrap
    send_sphere('0, '0, '0, '0, 1, 0);
    send_sphere(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 0, 0);
    send_sphere('0, '0, '0, 20'hFFFFF, 1, 0);
    send_sphere(20'd100, 20'd100, 20'd100, 20'd50, 0, 0);
    send_sphere(20'd120, 20'd100, 20'd100, 20'd50, 0, 0);
    send_sphere(20'd80, 20'd100, 20'd100, 20'd0, 0, 0);
    send_sphere(20'd300, 20'd100, 20'd100, 20'd0, 0, 0);
    send_sphere(20'd65500, 20'd100, 20'd100, 20'd0, 1, 0);
    set_box(13'd1);
    send_sphere(20'd10, 20'd250, 20'd5, 20'd1, 0, 0);
    send_sphere(20'd1000, 20'hAAAAA, 20'h55555, 20'd2, 0, 0);
    send_sphere(20'd128, 20'd128, 20'd128, 20'd0, 1, 0);
    set_box(13'd4);
    random_batch(MAX_SPHERES + 3, 2, 1);
    sent = 0;
    for (int p = 0; p < 6; p++) begin
      set_box(boxes[p]);
      for (int b = 0; b < 4; b++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 12);
        random_batch(n, $urandom_range(0, 2), $urandom_range(0, 4) == 0);
        sent += n;
      end
    end
    while (sent < 400) begin
      n = $urandom_range(1, 14);
      random_batch(n, $urandom_range(0, 2), $urandom_range(0, 4) == 0);
      sent += n;
    end
    in_ch.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS periodic_nearest_neighbor");
    end else begin
      $display("FAIL periodic_nearest_neighbor");
    end
    $finish;
  end
endmodule
